// ===== hdl/etf_pkg.sv =====
package etf_pkg;

    localparam int SecW   = 31;
    localparam int UsecW  = 20;
    localparam int DigN   = 10;
    localparam int StepN  = 31;
    localparam int CntW   = 6;

    // seconds / 60 as (seconds >> 2) * ceil(2^33 / 15) >> 33
    localparam logic [29:0] Recip15      = 30'd572662307;
    localparam logic [5:0]  Recip15Shift = 6'd33;

    typedef struct packed {
        logic [SecW-1:0]  seconds;
        logic [UsecW-1:0] microseconds;
    } time_in_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_out_t;

    localparam logic CFG_FRACTION_DIGITS = 1'b0;
    localparam logic CFG_FORMAT_MODE     = 1'b1;

    localparam logic [1:0] MODE_SECONDS = 2'd0;
    localparam logic [1:0] MODE_SUFFIX  = 2'd1;
    localparam logic [1:0] MODE_COLON   = 2'd2;
    localparam logic [1:0] MODE_MINUTES = 2'd3;

    typedef enum logic [1:0] {DIV_FRAC, DIV_TOTAL, DIV_MINS} div_sel_t;
    typedef enum logic [1:0] {SRC_HRS, SRC_MINS, SRC_SEC, SRC_FRAC} src_sel_t;
    typedef enum logic [2:0] {
        CH_NONE, CH_DIGIT, CH_HSEP, CH_MSEP, CH_ZERO, CH_POINT, CH_S
    } char_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIV_F, ST_DIV_A, ST_DIV_B, ST_DECIDE,
        ST_H_CONV, ST_H_EMIT, ST_H_SEP,
        ST_M_PAD, ST_M_CONV, ST_M_EMIT, ST_M_SEP,
        ST_S_PAD, ST_S_CONV, ST_S_EMIT,
        ST_F_POINT, ST_F_CONV, ST_F_EMIT, ST_SUFFIX
    } state_t;

    typedef struct packed {
        logic      accept;
        logic      div_run;
        div_sel_t  div_sel;
        logic      conv_run;
        src_sel_t  conv_sel;
        char_sel_t char_sel;
        logic      last;
    } etf_cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       conv_done;
        logic       last_digit;
        logic [1:0] mode;
        logic       digs_nz;
        logic       hrs_show;
        logic       mins_show;
        logic       pad_m;
        logic       pad_s;
    } etf_stat_t;

    // usec / 10^(6-d) as usec * frac_recip(d) >> frac_shift(d), exact below 2^20
    function automatic logic [20:0] frac_recip(input logic [2:0] d);
        case (d)
            3'd0:    frac_recip = 21'd1099512;
            3'd1:    frac_recip = 21'd1374390;
            3'd2:    frac_recip = 21'd1717987;
            3'd3:    frac_recip = 21'd1073742;
            3'd4:    frac_recip = 21'd1342178;
            3'd5:    frac_recip = 21'd1677722;
            default: frac_recip = 21'd1048576;
        endcase
    endfunction

    function automatic logic [5:0] frac_shift(input logic [2:0] d);
        case (d)
            3'd0:    frac_shift = 6'd40;
            3'd1:    frac_shift = 6'd37;
            3'd2:    frac_shift = 6'd34;
            3'd3:    frac_shift = 6'd30;
            3'd4:    frac_shift = 6'd27;
            3'd5:    frac_shift = 6'd24;
            default: frac_shift = 6'd20;
        endcase
    endfunction

endpackage

// ===== hdl/etf_ctrl.sv =====
module etf_ctrl
    import etf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  etf_stat_t stat,
    output etf_cmd_t  cmd,
    output logic      busy
);

    state_t state_reg, state_next;
    logic   sfx;
    state_t to_sec, to_min;

    assign sfx    = (stat.mode == MODE_SUFFIX) || (stat.mode == MODE_MINUTES);
    assign to_sec = stat.pad_s ? ST_S_PAD : ST_S_CONV;
    assign to_min = stat.pad_m ? ST_M_PAD : ST_M_CONV;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (start) state_next = ST_DIV_F;
            ST_DIV_F:   if (stat.div_done) state_next = ST_DIV_A;
            ST_DIV_A:   if (stat.div_done) state_next = ST_DIV_B;
            ST_DIV_B:   if (stat.div_done) state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (stat.mode == MODE_SECONDS)
                    state_next = ST_S_CONV;
                else if (stat.hrs_show)
                    state_next = ST_H_CONV;
                else if (stat.mins_show)
                    state_next = to_min;
                else
                    state_next = to_sec;
            end
            ST_H_CONV:  if (stat.conv_done) state_next = ST_H_EMIT;
            ST_H_EMIT:  if (stat.last_digit) state_next = ST_H_SEP;
            ST_H_SEP:   state_next = to_min;
            ST_M_PAD:   state_next = ST_M_CONV;
            ST_M_CONV:  if (stat.conv_done) state_next = ST_M_EMIT;
            ST_M_EMIT:  if (stat.last_digit) state_next = ST_M_SEP;
            ST_M_SEP:   state_next = to_sec;
            ST_S_PAD:   state_next = ST_S_CONV;
            ST_S_CONV:  if (stat.conv_done) state_next = ST_S_EMIT;
            ST_S_EMIT:
            begin
                if (stat.last_digit)
                    state_next = stat.digs_nz ? ST_F_POINT : (sfx ? ST_SUFFIX : ST_IDLE);
            end
            ST_F_POINT: state_next = ST_F_CONV;
            ST_F_CONV:  if (stat.conv_done) state_next = ST_F_EMIT;
            ST_F_EMIT:  if (stat.last_digit) state_next = sfx ? ST_SUFFIX : ST_IDLE;
            ST_SUFFIX:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.div_sel  = DIV_FRAC;
        cmd.conv_sel = SRC_SEC;
        cmd.char_sel = CH_NONE;
        busy         = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:    cmd.accept = start;
            ST_DIV_F:   begin cmd.div_run = 1'b1; cmd.div_sel = DIV_FRAC;  end
            ST_DIV_A:   begin cmd.div_run = 1'b1; cmd.div_sel = DIV_TOTAL; end
            ST_DIV_B:   begin cmd.div_run = 1'b1; cmd.div_sel = DIV_MINS;  end
            ST_H_CONV:  begin cmd.conv_run = 1'b1; cmd.conv_sel = SRC_HRS;  end
            ST_M_CONV:  begin cmd.conv_run = 1'b1; cmd.conv_sel = SRC_MINS; end
            ST_S_CONV:  begin cmd.conv_run = 1'b1; cmd.conv_sel = SRC_SEC;  end
            ST_F_CONV:  begin cmd.conv_run = 1'b1; cmd.conv_sel = SRC_FRAC; end
            ST_H_EMIT, ST_M_EMIT: cmd.char_sel = CH_DIGIT;
            ST_S_EMIT:
            begin
                cmd.char_sel = CH_DIGIT;
                cmd.last     = stat.last_digit && !stat.digs_nz && !sfx;
            end
            ST_F_EMIT:
            begin
                cmd.char_sel = CH_DIGIT;
                cmd.last     = stat.last_digit && !sfx;
            end
            ST_H_SEP:   cmd.char_sel = CH_HSEP;
            ST_M_SEP:   cmd.char_sel = CH_MSEP;
            ST_M_PAD, ST_S_PAD: cmd.char_sel = CH_ZERO;
            ST_F_POINT: cmd.char_sel = CH_POINT;
            ST_SUFFIX:
            begin
                cmd.char_sel = CH_S;
                cmd.last     = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/etf_datapath.sv =====
module etf_datapath
    import etf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  time_in_t  time_value,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [2:0] cfg_data,
    input  etf_cmd_t  cmd,
    output etf_stat_t stat,
    output char_out_t char_out,
    output logic      char_strobe
);

    logic [2:0]       fdig_reg;
    logic [1:0]       mode_reg;
    logic [2:0]       digs;
    logic [SecW-1:0]  total_reg;
    logic [UsecW-1:0] usec_reg;
    logic [UsecW-1:0] frac_reg;
    logic [25:0]      mtot_reg;
    logic [5:0]       sec60_reg;
    logic [19:0]      hrs_reg;
    logic [5:0]       min60_reg;

    logic [CntW-1:0]  div_cnt_reg;
    logic [58:0]      prod_reg;
    logic [SecW-1:0]  quot_reg;
    logic [SecW-1:0]  dividend;
    logic [28:0]      mul_a;
    logic [29:0]      mul_b;
    logic [5:0]       shamt;
    logic [SecW-1:0]  rem60;

    logic [CntW-1:0]  cv_cnt_reg;
    logic [SecW-1:0]  bin_reg;
    logic [4*DigN-1:0] bcd_reg;
    logic [4*DigN-1:0] bcd_adj;
    logic [SecW-1:0]  src;
    logic [3:0]       idx_reg;
    logic [3:0]       lead;
    logic [3:0]       digit;
    logic [7:0]       ch;

    localparam logic [CntW-1:0] DoneCnt    = CntW'(StepN + 1);
    localparam logic [CntW-1:0] DivDoneCnt = CntW'(2);

    assign digs = (fdig_reg > 3'd6) ? 3'd6 : fdig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fdig_reg <= 3'd3;
            mode_reg <= MODE_SUFFIX;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FRACTION_DIGITS)
                fdig_reg <= cfg_data;
            else
                mode_reg <= cfg_data[1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            total_reg <= time_value.seconds;
            usec_reg  <= time_value.microseconds;
        end
    end

    // reciprocal multiply: product, then shift, then remainder
    always_comb
    begin
        case (cmd.div_sel)
            DIV_FRAC:
            begin
                dividend = SecW'(usec_reg);
                mul_a    = 29'(usec_reg);
                mul_b    = 30'(frac_recip(digs));
                shamt    = frac_shift(digs);
            end
            DIV_TOTAL:
            begin
                dividend = total_reg;
                mul_a    = total_reg[SecW-1:2];
                mul_b    = Recip15;
                shamt    = Recip15Shift;
            end
            default:
            begin
                dividend = SecW'(mtot_reg);
                mul_a    = 29'(mtot_reg[25:2]);
                mul_b    = Recip15;
                shamt    = Recip15Shift;
            end
        endcase
    end

    assign rem60 = dividend - {quot_reg[SecW-7:0], 6'd0} + {quot_reg[SecW-3:0], 2'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (!cmd.div_run || div_cnt_reg == DivDoneCnt)
            div_cnt_reg <= '0;
        else
            div_cnt_reg <= div_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_run && div_cnt_reg == '0)
            prod_reg <= mul_a * mul_b;
        if (cmd.div_run && div_cnt_reg == CntW'(1))
            quot_reg <= SecW'(prod_reg >> shamt);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_run && div_cnt_reg == DivDoneCnt)
        begin
            case (cmd.div_sel)
                DIV_FRAC:  frac_reg <= quot_reg[UsecW-1:0];
                DIV_TOTAL:
                begin
                    mtot_reg  <= quot_reg[25:0];
                    sec60_reg <= rem60[5:0];
                end
                default:
                begin
                    hrs_reg   <= quot_reg[19:0];
                    min60_reg <= rem60[5:0];
                end
            endcase
        end
    end

    // binary to BCD, shift and add three
    always_comb
    begin
        case (cmd.conv_sel)
            SRC_HRS:  src = SecW'(hrs_reg);
            SRC_MINS: src = (mode_reg == MODE_MINUTES) ? SecW'(mtot_reg) : SecW'(min60_reg);
            SRC_SEC:  src = (mode_reg == MODE_SECONDS) ? total_reg : SecW'(sec60_reg);
            default:  src = SecW'(frac_reg);
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < DigN; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < DigN; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
                lead = 4'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_cnt_reg <= '0;
        else if (!cmd.conv_run || cv_cnt_reg == DoneCnt)
            cv_cnt_reg <= '0;
        else
            cv_cnt_reg <= cv_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.conv_run && cv_cnt_reg == '0)
        begin
            bin_reg <= src;
            bcd_reg <= '0;
        end
        else if (cmd.conv_run && cv_cnt_reg != DoneCnt)
        begin
            bcd_reg <= {bcd_adj[4*DigN-2:0], bin_reg[SecW-1]};
            bin_reg <= {bin_reg[SecW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.conv_run && cv_cnt_reg == DoneCnt)
            idx_reg <= (cmd.conv_sel == SRC_FRAC) ? 4'(digs - 3'd1) : lead;
        else if (cmd.char_sel == CH_DIGIT)
            idx_reg <= idx_reg - 1'b1;
    end

    assign digit = bcd_reg[4*idx_reg +: 4];

    always_comb
    begin
        case (cmd.char_sel)
            CH_DIGIT: ch = 8'h30 + {4'd0, digit};
            CH_HSEP:  ch = (mode_reg == MODE_COLON) ? 8'h3A : 8'h68;
            CH_MSEP:  ch = (mode_reg == MODE_COLON) ? 8'h3A : 8'h6D;
            CH_ZERO:  ch = 8'h30;
            CH_POINT: ch = 8'h2E;
            CH_S:     ch = 8'h73;
            default:  ch = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_strobe <= 1'b0;
        else
            char_strobe <= (cmd.char_sel != CH_NONE);
    end

    always_ff @(posedge clk)
    begin
        char_out.char_code <= ch;
        char_out.last_char <= cmd.last;
    end

    assign stat.div_done   = (div_cnt_reg == DivDoneCnt);
    assign stat.conv_done  = (cv_cnt_reg == DoneCnt);
    assign stat.last_digit = (idx_reg == 4'd0);
    assign stat.mode       = mode_reg;
    assign stat.digs_nz    = (digs != 3'd0);
    assign stat.hrs_show   = (mode_reg != MODE_MINUTES) && (hrs_reg != 20'd0);
    assign stat.mins_show  = (mode_reg == MODE_MINUTES) || stat.hrs_show || (min60_reg != 6'd0);
    assign stat.pad_m      = (mode_reg == MODE_COLON) && (min60_reg < 6'd10) && (hrs_reg != 20'd0);
    assign stat.pad_s      = (mode_reg == MODE_COLON) && (sec60_reg < 6'd10)
                             && (total_reg >= SecW'(60));

endmodule

// ===== hdl/elapsed_time_text_formatter.sv =====
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------
// input     | start, busy               | time_value (time_in_t)
// result    | char_strobe (one cycle)   | char_out (char_out_t)
// config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// One item at a time: three reciprocal-multiply divides (fraction, /60, /60),
// then a 31-step BCD converter runs once per printed number (up to four),
// then one character a cycle.
// rst_n clears the controller and strobe; registers reset to 3 digits, mode 1.
// Results cannot be stalled; busy drops as the last character is issued.
module elapsed_time_text_formatter
    import etf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  time_in_t   time_value,
    output char_out_t  char_out,
    output logic       char_strobe,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [2:0] cfg_data
);

    etf_cmd_t  cmd;
    etf_stat_t stat;

    assign cfg_ready = 1'b1;

    etf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    etf_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .time_value  (time_value),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .char_out    (char_out),
        .char_strobe (char_strobe)
    );

endmodule

// ===== hdl/etf_checker.sv =====
module etf_checker
    import etf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input char_out_t char_out,
    input logic      char_strobe,
    input logic      cfg_ready
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_no_early_char: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !char_strobe)
        else $error("character straight after accept");

    a_rose_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without start");

    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        char_strobe |-> (char_out.char_code != 8'h00))
        else $error("null character issued");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind elapsed_time_text_formatter etf_checker u_etf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .char_out    (char_out),
    .char_strobe (char_strobe),
    .cfg_ready   (cfg_ready)
);
